@@ rtl/core/arbl_pkg.sv @@
// Types, character codes and decimal conversion helpers for the
// range/bearing line parser. No dependencies; used by every rtl/core file but arbl_checker.
package arbl_pkg;

   // line geometry
   localparam int unsigned LINE_LEN  = 9;
   localparam logic [3:0]  COUNT_MAX = 4'd9;
   localparam logic [3:0]  COUNT_SAT = 4'd10;

   // character codes
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // value register reset contents
   localparam logic signed [14:0] DISTANCE_RESET = 15'sd0;
   localparam logic signed [10:0] BEARING_RESET  = 11'sd10;

   // conversion phases
   localparam logic [1:0] PH_LEAD   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_STOP   = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       overrun;
   } item_type;

   typedef struct packed {
      logic signed [14:0] distance_value;
      logic signed [10:0] bearing_value;
      logic               frame_accepted;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // signed decimal value of up to four characters, index 0 first
   function automatic logic signed [14:0] parse_dec(input logic [3:0][7:0] chars,
                                                    input logic [2:0] len);
      logic [1:0]  phase;
      logic        neg;
      logic [14:0] acc;
      logic [7:0]  c;
      phase = PH_LEAD;
      neg   = 1'b0;
      acc   = '0;
      for (int i = 0; i < 4; i++) begin
         c = chars[i];
         if (3'(i) < len) begin
            if (phase == PH_LEAD) begin
               if (is_space(c)) begin
                  phase = PH_LEAD;
               end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                  neg   = (c == CHAR_MINUS);
                  phase = PH_DIGITS;
               end else if (is_digit(c)) begin
                  acc   = {11'd0, c[3:0]};
                  phase = PH_DIGITS;
               end else begin
                  phase = PH_STOP;
               end
            end else if (phase == PH_DIGITS) begin
               if (is_digit(c)) begin
                  acc = 15'(acc * 15'd10) + {11'd0, c[3:0]};
               end else begin
                  phase = PH_STOP;
               end
            end
         end
      end
      return neg ? -$signed(acc) : $signed(acc);
   endfunction

endpackage

@@ rtl/core/ascii_range_bearing_line_parser.sv @@
// Range/bearing line parser top level: input register, line core, result register.
// Depends on arbl_pkg, arbl_in_stage, arbl_line_core and arbl_out_stage.
//
// Takes one received byte per item and returns one result per item. Bytes build
// a line of up to nine characters; CR or LF ends it, and a line of exactly nine
// bytes of the form d<4 chars>b<3 chars> updates distance and bearing, each
// read as a signed decimal (leading blanks, optional sign, digits up to the
// first non-digit). Overrun discards the partial line. Every result carries the
// current distance and bearing, and frame_accepted marks the item that updated
// them. An accepted item passes the input register and then the result
// register before its result leaves; with the result side ready a new item is
// taken every cycle, limited only by the input register and the result register
// each holding one item.
module ascii_range_bearing_line_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] overrun
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] distance_value, [25:15] bearing_value, zeros
   output logic [0:0]  rsp_tuser    // [0] frame_accepted
);
   import arbl_pkg::*;

   item_type   in_item;
   item_type   hold_item;
   logic       hold_valid;
   logic       take;
   result_type core_result;
   result_type out_result;

   assign in_item.rx_byte = req_tdata;
   assign in_item.overrun = req_tuser[0];

   // input register
   arbl_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   // line state and conversion
   arbl_line_core u_line_core (
      .clock  (clock),
      .reset  (reset),
      .step   (hold_valid && take),
      .item   (hold_item),
      .result (core_result)
   );

   // result register
   arbl_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (hold_valid),
      .load_result (core_result),
      .take        (take),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (out_result)
   );

   assign rsp_tdata = {6'd0, out_result.bearing_value, out_result.distance_value};
   assign rsp_tuser = out_result.frame_accepted;

endmodule

@@ rtl/core/arbl_in_stage.sv @@
// Input register for received bytes; takes a new item when empty or whenever the
// downstream stage moves. Depends on arbl_pkg.
module arbl_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  arbl_pkg::item_type in_item,
   input  logic              take,
   output logic              hold_valid,
   output arbl_pkg::item_type hold_item
);
   import arbl_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // accept when empty or when the held item moves on this cycle
   assign in_ready = !valid_ff || take;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

@@ rtl/core/arbl_line_core.sv @@
// Line buffer, character count, value registers and field conversion.
// Depends on arbl_pkg.
module arbl_line_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  arbl_pkg::item_type  item,
   output arbl_pkg::result_type result
);
   import arbl_pkg::*;

   logic [7:0]         store_ff [LINE_LEN];
   logic [3:0]         count_ff, count_in;
   logic signed [14:0] distance_ff, distance_in;
   logic signed [10:0] bearing_ff, bearing_in;
   logic               is_term;
   logic               frame_ok;
   logic [3:0][7:0]    dist_chars;
   logic [3:0][7:0]    bear_chars;
   logic signed [14:0] bear_wide;

   assign is_term = (item.rx_byte == CHAR_LF) || (item.rx_byte == CHAR_CR);

   // a full line with the two tag characters in place
   assign frame_ok = !item.overrun && is_term && (count_ff == COUNT_MAX) &&
                     (store_ff[0] == CHAR_D) && (store_ff[5] == CHAR_B);

   // field characters, first character at index 0
   assign dist_chars = {store_ff[4], store_ff[3], store_ff[2], store_ff[1]};
   assign bear_chars = {8'h00, store_ff[8], store_ff[7], store_ff[6]};
   assign bear_wide  = parse_dec(bear_chars, 3'd3);

   // next count and values
   always_comb begin
      count_in    = count_ff;
      distance_in = distance_ff;
      bearing_in  = bearing_ff;
      if (item.overrun || is_term) begin
         count_in = '0;
      end else if (count_ff < COUNT_SAT) begin
         count_in = count_ff + 4'd1;
      end
      if (frame_ok) begin
         distance_in = parse_dec(dist_chars, 3'd4);
         bearing_in  = bear_wide[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         distance_ff <= DISTANCE_RESET;
         bearing_ff  <= BEARING_RESET;
      end else if (step) begin
         count_ff    <= count_in;
         distance_ff <= distance_in;
         bearing_ff  <= bearing_in;
      end
   end

   // line buffer, written while the line still fits
   always_ff @(posedge clock) begin
      if (step && !item.overrun && !is_term && count_ff < COUNT_MAX) begin
         store_ff[count_ff] <= item.rx_byte;
      end
   end

   assign result.distance_value = distance_in;
   assign result.bearing_value  = bearing_in;
   assign result.frame_accepted = frame_ok;

endmodule

@@ rtl/core/arbl_out_stage.sv @@
// Result register in front of the output channel.
// Depends on arbl_pkg.
module arbl_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  arbl_pkg::result_type load_result,
   output logic                 take,
   output logic                 out_valid,
   input  logic                 out_ready,
   output arbl_pkg::result_type out_result
);
   import arbl_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   // room when empty or when the held item leaves this cycle
   assign take     = !valid_ff || out_ready;
   assign valid_in = take ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && load_valid) begin
         result_ff <= load_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

@@ rtl/core/arbl_checker.sv @@
// Port-level checks for the range/bearing line parser, bound to its top level.
// Depends only on the top level's ports.
module arbl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:26] == 6'd0)
      else $error("rsp padding not zero");

   // values stay within what four and three characters can spell
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[14:0]) >= -15'sd999) &&
                     ($signed(rsp_tdata[14:0]) <= 15'sd9999) &&
                     ($signed(rsp_tdata[25:15]) >= -11'sd99) &&
                     ($signed(rsp_tdata[25:15]) <= 11'sd999))
      else $error("rsp value out of range");

   // input is never held off while the result side is ready
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req stalled with rsp ready");

   // an offered item stays offered until taken
   a_req_wait: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid)
      else $error("req item withdrawn while waiting");

endmodule

bind ascii_range_bearing_line_parser arbl_checker u_arbl_checker (.*);

@@ dv/ascii_range_bearing_line_parser_tb.sv @@
// Self-checking testbench for the range/bearing line parser: a directed byte script,
// then random lines, with random stalls on both streams and a scoreboard.
// Depends on arbl_pkg and ascii_range_bearing_line_parser.
`timescale 1ns / 1ps

module ascii_range_bearing_line_parser_tb;
   import arbl_pkg::*;

   localparam int ITEM_TARGET  = 1950;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 250;
   localparam int MAX_REPORTS  = 10;
   localparam int SCRIPT_ROWS  = 25;
   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;

   // one row of the directed script; want fields only meaningful when pinned
   typedef struct packed {
      logic [7:0]         ch;
      logic               ovr;
      logic               pinned;
      logic signed [14:0] distance;
      logic signed [10:0] brg;
      logic               acc;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic [0:0]  req_tuser;   // [0] overrun
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [14:0] distance_value, [25:15] bearing_value, zeros
   logic [0:0]  rsp_tuser;   // [0] frame_accepted

   // line tracking state mirrored from the block
   logic [7:0]         line_chars [LINE_LEN];
   logic [3:0]         line_count;
   logic signed [14:0] range_now;
   logic signed [10:0] bearing_now;

   result_type     pending_results [$];
   script_row_type script [SCRIPT_ROWS];
   int          sent_bytes   = 0;
   int          checked      = 0;
   int          errors       = 0;
   int          idle_cycles  = 0;
   bit          quiet        = 1'b0;
   bit          stall_req    = 1'b0;

   ascii_range_bearing_line_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit blank_char(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // strtol-style decimal value of line_chars[first +: len]
   function automatic int decimal_of(input int first, input int len);
      int i;
      bit neg;
      int acc;
      i   = 0;
      neg = 1'b0;
      acc = 0;
      while (i < len && blank_char(line_chars[first + i]))
         i++;
      if (i < len && (line_chars[first + i] == CHAR_PLUS ||
                      line_chars[first + i] == CHAR_MINUS)) begin
         neg = (line_chars[first + i] == CHAR_MINUS);
         i++;
      end
      while (i < len && line_chars[first + i] >= CHAR_ZERO &&
             line_chars[first + i] <= CHAR_NINE) begin
         acc = acc * 10 + int'(line_chars[first + i] - CHAR_ZERO);
         i++;
      end
      return neg ? -acc : acc;
   endfunction

   // advance the line state by one accepted byte and form its result
   task automatic track_byte(input logic [7:0] ch, input logic ovr, output result_type r);
      r.frame_accepted = 1'b0;
      if (ovr) begin
         line_count = '0;
      end else if (ch == CHAR_LF || ch == CHAR_CR) begin
         if (line_count == COUNT_MAX && line_chars[0] == CHAR_D &&
             line_chars[5] == CHAR_B) begin
            range_now        = 15'(decimal_of(1, 4));
            bearing_now      = 11'(decimal_of(6, 3));
            r.frame_accepted = 1'b1;
         end
         line_count = '0;
      end else begin
         if (line_count < COUNT_MAX)
            line_chars[line_count] = ch;
         if (line_count < COUNT_SAT)
            line_count++;
      end
      r.distance_value = range_now;
      r.bearing_value  = bearing_now;
   endtask

   // sender gap: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // offer one byte, wait for the handshake, record what must come back
   task automatic push_byte(input logic [7:0] ch, input logic ovr, input bit pinned,
                            input result_type want);
      result_type r;
      int gap;
      @(negedge clock);
      req_tdata  = ch;
      req_tuser  = ovr;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      track_byte(ch, ovr, r);
      pending_results.push_back(pinned ? want : r);
      sent_bytes++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // character for a number group: digits, blanks, signs, odd bytes
   function automatic logic [7:0] group_char();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return CHAR_ZERO + 8'($urandom_range(0, 9));
      case (r)
         10: return CHAR_SPACE;
         11: begin
            case ($urandom_range(0, 2))
               0: return CHAR_TAB;
               1: return CHAR_VT;
               default: return CHAR_FF;
            endcase
         end
         12: return CHAR_PLUS;
         13: return CHAR_MINUS;
         14: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   // one random line: mostly well formed, the rest long, short or noise
   task automatic send_line();
      logic [7:0] chars [16];
      logic       ovrs  [16];
      int         n;
      int         kind;
      kind = $urandom_range(0, 99);
      for (int k = 0; k < 16; k++) begin
         chars[k] = group_char();
         ovrs[k]  = 1'b0;
      end
      chars[0] = CHAR_D;
      chars[5] = CHAR_B;
      if (kind < 70) begin
         n = 9;
         if ($urandom_range(0, 9) == 0)
            chars[$urandom_range(0, 8)] = 8'($urandom);
         if ($urandom_range(0, 19) == 0)
            ovrs[$urandom_range(0, 9)] = 1'b1;
      end else if (kind < 80) begin
         n = $urandom_range(10, 14);
      end else if (kind < 90) begin
         n = $urandom_range(0, 8);
      end else begin
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++) begin
            chars[k] = 8'($urandom);
            ovrs[k]  = ($urandom_range(0, 3) == 0);
         end
      end
      if (kind < 90) begin
         chars[n] = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
         n++;
      end
      for (int k = 0; k < n; k++)
         push_byte(chars[k], ovrs[k], 1'b0, '0);
   endtask

   // result side: random stalls, a forced long hold on request
   initial begin
      int r;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_req) begin
            stall_req  = 1'b0;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (quiet) begin
            rsp_tready = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_tready = 1'b1;
            end else if (r < 95) begin
               rsp_tready = 1'b0;
               repeat ($urandom_range(0, 3)) @(negedge clock);
            end else begin
               rsp_tready = 1'b0;
               repeat ($urandom_range(10, 40)) @(negedge clock);
            end
         end
      end
   end

   // scoreboard: compare each result with the oldest expectation
   always @(posedge clock) begin : result_check
      result_type         want;
      logic signed [14:0] got_dist;
      logic signed [10:0] got_brg;
      logic               got_acc;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_dist = rsp_tdata[14:0];
         got_brg  = rsp_tdata[25:15];
         got_acc  = rsp_tuser[0];
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected result: distance %0d bearing %0d accepted %0b",
                        got_dist, got_brg, got_acc);
         end else begin
            want = pending_results.pop_front();
            if (got_dist !== want.distance_value || got_brg !== want.bearing_value ||
                got_acc !== want.frame_accepted) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("result %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b", checked,
                           want.distance_value, want.bearing_value, want.frame_accepted,
                           got_dist, got_brg, got_acc);
            end
         end
         checked++;
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("** ascii_range_bearing_line_parser: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      result_type want;
      bit         paused;
      paused      = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      line_count  = '0;
      range_now   = DISTANCE_RESET;
      bearing_now = BEARING_RESET;
      for (int k = 0; k < LINE_LEN; k++)
         line_chars[k] = '0;

      // empty line, largest and smallest values, overrun, short line
      script = '{
         '{CHAR_CR,    1'b0, 1'b1, 15'sd0,    11'sd10,  1'b0},
         '{CHAR_D,     1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_B,     1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_LF,    1'b0, 1'b1, 15'sd9999, 11'sd999, 1'b1},
         '{CHAR_D,     1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_MINUS, 1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_B,     1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_MINUS, 1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_NINE,  1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_CR,    1'b0, 1'b1, -15'sd999, -11'sd99, 1'b1},
         '{8'hFF,      1'b1, 1'b1, -15'sd999, -11'sd99, 1'b0},
         '{CHAR_D,     1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{8'h00,      1'b0, 1'b0, 15'sd0,    11'sd0,   1'b0},
         '{CHAR_LF,    1'b0, 1'b1, -15'sd999, -11'sd99, 1'b0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < SCRIPT_ROWS; k++) begin
         want.distance_value = script[k].distance;
         want.bearing_value  = script[k].brg;
         want.frame_accepted = script[k].acc;
         push_byte(script[k].ch, script[k].ovr, script[k].pinned, want);
      end
      wait_for_results();

      // random lines; the result side holds off once early so the block backs up
      stall_req = 1'b1;
      while (sent_bytes < ITEM_TARGET) begin
         if (!paused && sent_bytes > ITEM_TARGET / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 24) == 0)
            quiet = !quiet;
         send_line();
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         errors++;
      if (errors == 0)
         $display("** ascii_range_bearing_line_parser: PASSED **");
      else
         $display("** ascii_range_bearing_line_parser: FAILED **");
      $finish;
   end

endmodule
